@@ design/phwf_pkg.sv @@
// shared types, constants and hann coefficient table builder for the pcm hann window framer
`default_nettype none

package phwf_pkg;

    localparam int FRAME_LEN  = 512;
    localparam int SLIDE_STEP = 256;
    localparam int COEF_BITS  = 16;

    localparam int ADDR_W   = $clog2(FRAME_LEN);
    localparam int FILL_W   = $clog2(FRAME_LEN + 1);
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = SAMPLE_W + 1;
    localparam int PROD_W   = SUM_W + COEF_BITS + 1;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // fixed-point constants for the table build
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] COEF_MAX    = (64'd1 << COEF_BITS) - 64'd1;
    localparam logic [63:0] HANN_DEN    = (FRAME_LEN > 1) ? 64'(FRAME_LEN - 1) : 64'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_SLIDE = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_FORMAT = 1'b0,
        CFG_MONO_MODE     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RD_SUM = 2'd1,
        ST_RD_MUL = 2'd2,
        ST_DONE   = 2'd3
    } state_t;

    typedef struct packed {
        logic accept;
        logic stage_sum;
        logic stage_mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic item_is_read;
    } sts_t;

    typedef logic [FRAME_LEN-1:0][COEF_BITS-1:0] hann_tab_t;

    // sine in q30 by taylor series up to x^11, angle folded into the first quadrant
    function automatic logic [63:0] sin_q30(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x = x_in;
        if (x > PI_Q30)
            x = PI_Q30;
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        return s;
    endfunction

    // symmetric hann coefficients, evaluated at elaboration only
    function automatic hann_tab_t build_hann();
        hann_tab_t   tab;
        logic [63:0] ang;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] c;
        int          n;
        for (n = 0; n < FRAME_LEN; n++)
        begin
            ang = (64'(n) * PI_Q30 + HANN_DEN / 2) / HANN_DEN;
            s   = sin_q30(ang);
            w   = (s * s) >> 30;
            c   = (w * COEF_MAX + (Q30_ONE >> 1)) >> 30;
            if (c > COEF_MAX)
                c = COEF_MAX;
            tab[n] = c[COEF_BITS-1:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

@@ design/phwf_in_if.sv @@
// input channel: operation code, raw stereo samples and read index
`default_nettype none

interface phwf_in_if;
    logic                              valid;
    logic                              ready;
    logic [phwf_pkg::FUNC_W-1:0]       func;
    logic [phwf_pkg::SAMPLE_W-1:0]     chan_a_sample;
    logic [phwf_pkg::SAMPLE_W-1:0]     chan_b_sample;
    logic [phwf_pkg::ADDR_W-1:0]       read_index;

    modport source (
        output valid, func, chan_a_sample, chan_b_sample, read_index,
        input  ready
    );
    modport sink (
        input  valid, func, chan_a_sample, chan_b_sample, read_index,
        output ready
    );
endinterface

`default_nettype wire

@@ design/phwf_out_if.sv @@
// result channel: push status, fill level and windowed value
`default_nettype none

interface phwf_out_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic [phwf_pkg::FILL_W-1:0]         fill_level;
    logic signed [phwf_pkg::SUM_W-1:0]   windowed_value;

    modport source (
        output valid, accepted, fill_level, windowed_value,
        input  ready
    );
    modport sink (
        input  valid, accepted, fill_level, windowed_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/phwf_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module phwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/phwf_ctrl.sv @@
// controller: sequences each beat through the datapath and owns the result valid
`default_nettype none

module phwf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  wire logic           result_ready,
    input  wire phwf_pkg::sts_t sts,
    output phwf_pkg::cmd_t      cmd
);

    phwf_pkg::state_t state_reg;
    phwf_pkg::state_t state_next;
    logic             result_valid_reg;
    logic             result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= phwf_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        cmd               = '0;
        item_ready        = 1'b0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            phwf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.item_is_read ? phwf_pkg::ST_RD_SUM : phwf_pkg::ST_DONE;
                end
            end
            phwf_pkg::ST_RD_SUM:
            begin
                cmd.stage_sum = 1'b1;
                state_next    = phwf_pkg::ST_RD_MUL;
            end
            phwf_pkg::ST_RD_MUL:
            begin
                cmd.stage_mul = 1'b1;
                state_next    = phwf_pkg::ST_DONE;
            end
            phwf_pkg::ST_DONE:
            begin
                // hand over once the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_out      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = phwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phwf_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;

`ifndef SYNTH
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == phwf_pkg::ST_DONE))
        else $error("result valid rose without a finished beat");

    a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !cmd.accept)
        else $error("two beats accepted back to back");
`endif

endmodule

`default_nettype wire

@@ design/phwf_dp.sv @@
// datapath: config registers, frame stores, fill/offset bookkeeping and windowing multiply
`default_nettype none

module phwf_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [phwf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [phwf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [phwf_pkg::FUNC_W-1:0]          item_func,
    input  wire logic [phwf_pkg::SAMPLE_W-1:0]        item_chan_a,
    input  wire logic [phwf_pkg::SAMPLE_W-1:0]        item_chan_b,
    input  wire logic [phwf_pkg::ADDR_W-1:0]          item_read_index,
    input  wire phwf_pkg::cmd_t                       cmd,
    output phwf_pkg::sts_t                            sts,
    output logic                                      out_accepted,
    output logic [phwf_pkg::FILL_W-1:0]               out_fill_level,
    output logic signed [phwf_pkg::SUM_W-1:0]         out_windowed_value
);

    localparam int AW = phwf_pkg::ADDR_W;
    localparam int FW = phwf_pkg::FILL_W;
    localparam int SW = phwf_pkg::SAMPLE_W;
    localparam int CB = phwf_pkg::COEF_BITS;

    localparam logic [FW-1:0] FILL_FULL  = FW'(phwf_pkg::FRAME_LEN);
    localparam logic [FW-1:0] FILL_SLIDE = FW'(phwf_pkg::SLIDE_STEP);
    localparam logic [AW-1:0] START_INC  = AW'(phwf_pkg::SLIDE_STEP % phwf_pkg::FRAME_LEN);

    localparam phwf_pkg::hann_tab_t HANN_TABLE = phwf_pkg::build_hann();

    function automatic logic [SW-1:0] normalize(input phwf_pkg::fmt_t f,
                                                input logic [SW-1:0] r);
        logic [SW-1:0] v;
        case (f)
            phwf_pkg::FMT_U8:  v = {~r[7], r[6:0], 24'd0};
            phwf_pkg::FMT_S16: v = {r[15:0], 16'd0};
            phwf_pkg::FMT_S24: v = {r[23:0], 8'd0};
            phwf_pkg::FMT_S32: v = r;
            default:           v = r;
        endcase
        return v;
    endfunction

    phwf_pkg::fmt_t            fmt_reg;
    logic                      mono_reg;
    logic [FW-1:0]             fill_reg;
    logic [AW-1:0]             start_reg;

    logic                      acc_reg;
    logic                      hit_reg;
    logic [AW-1:0]             idx_reg;
    logic signed [phwf_pkg::SUM_W-1:0]  sum_reg;
    logic [CB-1:0]             coef_reg;
    logic signed [phwf_pkg::PROD_W-1:0] prod_reg;

    logic                      out_accepted_reg;
    logic [FW-1:0]             out_fill_reg;
    logic signed [phwf_pkg::SUM_W-1:0]  out_windowed_reg;

    logic                      is_push;
    logic                      is_read;
    logic                      is_slide;
    logic                      is_clear;
    logic                      full;
    logic                      ram_we;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [SW-1:0]             norm_a;
    logic [SW-1:0]             norm_b;
    logic [SW-1:0]             rd_a;
    logic [SW-1:0]             rd_b;

    assign is_push  = item_func == phwf_pkg::FUNC_PUSH;
    assign is_read  = item_func == phwf_pkg::FUNC_READ;
    assign is_slide = item_func == phwf_pkg::FUNC_SLIDE;
    assign is_clear = item_func == phwf_pkg::FUNC_CLEAR;
    assign full     = fill_reg == FILL_FULL;

    assign sts.item_is_read = is_read;

    assign norm_a  = normalize(fmt_reg, item_chan_a);
    assign norm_b  = mono_reg ? norm_a : normalize(fmt_reg, item_chan_b);
    assign ram_we  = cmd.accept && is_push && !full;
    // index zero is the oldest entry, physical slot wraps around the frame
    assign wr_addr = start_reg + fill_reg[AW-1:0];
    assign rd_addr = start_reg + item_read_index;

    phwf_ram #(
        .WIDTH (SW),
        .DEPTH (phwf_pkg::FRAME_LEN)
    ) u_store_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (norm_a),
        .raddr (rd_addr),
        .rdata (rd_a)
    );

    phwf_ram #(
        .WIDTH (SW),
        .DEPTH (phwf_pkg::FRAME_LEN)
    ) u_store_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (norm_b),
        .raddr (rd_addr),
        .rdata (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= phwf_pkg::FMT_S16;
            mono_reg  <= 1'b0;
            fill_reg  <= '0;
            start_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (phwf_pkg::cfg_idx_t'(cfg_index))
                    phwf_pkg::CFG_SAMPLE_FORMAT: fmt_reg  <= phwf_pkg::fmt_t'(cfg_data[1:0]);
                    phwf_pkg::CFG_MONO_MODE:     mono_reg <= cfg_data[0];
                    default:                     mono_reg <= mono_reg;
                endcase
            end
            if (cmd.accept)
            begin
                if (ram_we)
                    fill_reg <= fill_reg + FW'(1);
                else if (is_slide)
                begin
                    fill_reg  <= (fill_reg > FILL_SLIDE) ? fill_reg - FILL_SLIDE : '0;
                    start_reg <= start_reg + START_INC;
                end
                else if (is_clear)
                    fill_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_reg <= ram_we;
            hit_reg <= is_read && ({1'b0, item_read_index} < fill_reg);
            idx_reg <= item_read_index;
        end
        if (cmd.stage_sum)
        begin
            sum_reg  <= $signed({rd_a[SW-1], rd_a}) + $signed({rd_b[SW-1], rd_b});
            coef_reg <= HANN_TABLE[idx_reg];
        end
        // signed product, taking the upper bits below gives the floor
        if (cmd.stage_mul)
            prod_reg <= sum_reg * $signed({1'b0, coef_reg});
        if (cmd.load_out)
        begin
            out_accepted_reg <= acc_reg;
            out_fill_reg     <= fill_reg;
            out_windowed_reg <= hit_reg ? prod_reg[CB +: phwf_pkg::SUM_W] : '0;
        end
    end

    assign out_accepted       = out_accepted_reg;
    assign out_fill_level     = out_fill_reg;
    assign out_windowed_value = out_windowed_reg;

`ifndef SYNTH
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond frame length");

    a_push_grows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("stored push did not advance fill count");
`endif

endmodule

`default_nettype wire

@@ design/pcm_hann_window_framer.sv @@
// top level of the pcm hann window framer: controller, datapath and channel wiring
`default_nettype none

// Collects normalized stereo samples (signed q1.31) in a 512-entry circular
// frame and returns Hann-windowed channel sums (q2.31) for an fft. A push,
// slide or clear beat goes from acceptance straight to the done state, where
// its result is loaded into the output register. A read goes through the
// store read at acceptance, then channel add, coefficient multiply and output
// load. The controller works on one beat at a time; the next beat is taken as
// soon as the previous result sits in the output register, even if not yet
// taken. While that register still holds a result, a finished beat waits for
// it to be taken.
// The sample stores are block rams with no clearing pass: a read only uses an
// entry after it has been written, so the block is ready right after reset.
// Configuration writes (sample format, mono mode) belong while the block is
// idle.

module pcm_hann_window_framer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    phwf_in_if.sink                                  items,
    phwf_out_if.source                               results,
    input  wire logic                                cfg_we,
    input  wire logic [phwf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [phwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    phwf_pkg::cmd_t cmd;
    phwf_pkg::sts_t sts;

    phwf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (items.valid),
        .item_ready   (items.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    phwf_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .item_func          (items.func),
        .item_chan_a        (items.chan_a_sample),
        .item_chan_b        (items.chan_b_sample),
        .item_read_index    (items.read_index),
        .cmd                (cmd),
        .sts                (sts),
        .out_accepted       (results.accepted),
        .out_fill_level     (results.fill_level),
        .out_windowed_value (results.windowed_value)
    );

endmodule

`default_nettype wire

@@ test/tb_pcm_hann_window_framer.sv @@
// testbench for the pcm hann window framer: directed table, random phases, scoreboard
`default_nettype none

module tb_pcm_hann_window_framer;
    import phwf_pkg::*;

    localparam longint unsigned ANG_ONE     = 64'd1 << 30;
    localparam longint unsigned ANG_PI      = 64'd3373259426;
    localparam longint unsigned ANG_HALF_PI = 64'd1686629713;
    localparam longint unsigned COEF_TOP    = (64'd1 << COEF_BITS) - 64'd1;
    localparam longint unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};
    localparam int DIRECTED_ROWS = 19;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 120;

    typedef struct {
        func_t             func;
        logic [31:0]       a_raw;
        logic [31:0]       b_raw;
        logic [ADDR_W-1:0] idx;
    } beat_t;

    typedef struct {
        logic                    accepted;
        logic [FILL_W-1:0]       fill;
        logic signed [SUM_W-1:0] windowed;
    } frame_result_t;

    typedef struct {
        func_t                   func;
        logic [31:0]             a_raw;
        logic [31:0]             b_raw;
        logic [ADDR_W-1:0]       idx;
        int                      reps;
        bit                      typed;
        logic                    accepted;
        logic [FILL_W-1:0]       fill;
        logic signed [SUM_W-1:0] windowed;
    } plan_row_t;

    typedef struct {
        fmt_t fmt;
        logic mono;
        int   send_pct;
        int   recv_pct;
    } phase_cfg_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    phwf_in_if  items_ch ();
    phwf_out_if results_ch ();

    pcm_hann_window_framer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the frame contents and window
    logic [31:0]          win_a_mem [FRAME_LEN];
    logic [31:0]          win_b_mem [FRAME_LEN];
    logic [COEF_BITS-1:0] hann_coef [FRAME_LEN];
    int                   win_fill;
    int                   win_start;
    fmt_t                 cur_fmt;
    logic                 cur_mono;

    frame_result_t pending_results [$];
    int            mismatches;
    int            beats_sent;
    int            send_pct;
    int            recv_pct;
    int            hold_request;

    plan_row_t plan [DIRECTED_ROWS] = '{
        '{FUNC_READ,  32'h0,        32'h0,        9'd0,   1,   1'b1, 1'b0, 10'd0,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd511, 1,   1'b1, 1'b0, 10'd0,   33'sd0},
        '{FUNC_PUSH,  32'h00007FFF, 32'hFFFF8000, 9'd0,   1,   1'b1, 1'b1, 10'd1,   33'sd0},
        '{FUNC_PUSH,  32'h00008000, 32'hABCD8000, 9'd0,   1,   1'b1, 1'b1, 10'd2,   33'sd0},
        '{FUNC_PUSH,  32'hFFFF7FFF, 32'h00007FFF, 9'd0,   1,   1'b1, 1'b1, 10'd3,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd0,   1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd1,   1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd2,   1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd3,   1,   1'b1, 1'b0, 10'd3,   33'sd0},
        '{FUNC_SLIDE, 32'h0,        32'h0,        9'd0,   1,   1'b1, 1'b0, 10'd0,   33'sd0},
        '{FUNC_CLEAR, 32'h0,        32'h0,        9'd0,   1,   1'b1, 1'b0, 10'd0,   33'sd0},
        '{FUNC_PUSH,  32'h0,        32'h0,        9'd0,   511, 1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_PUSH,  32'hFFFFFFFF, 32'h80000000, 9'd0,   1,   1'b1, 1'b1, 10'd512, 33'sd0},
        '{FUNC_PUSH,  32'h12345678, 32'h9ABCDEF0, 9'd0,   1,   1'b1, 1'b0, 10'd512, 33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd511, 1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd256, 1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_SLIDE, 32'h0,        32'h0,        9'd0,   1,   1'b1, 1'b0, 10'd256, 33'sd0},
        '{FUNC_READ,  32'h0,        32'h0,        9'd255, 1,   1'b0, 1'b0, 10'd0,   33'sd0},
        '{FUNC_CLEAR, 32'h0,        32'h0,        9'd0,   1,   1'b1, 1'b0, 10'd0,   33'sd0}
    };

    phase_cfg_t phases [PHASES] = '{
        '{FMT_U8,  1'b0, 0,  0},
        '{FMT_S16, 1'b1, 67, 0},
        '{FMT_S24, 1'b0, 0,  67},
        '{FMT_S32, 1'b1, 23, 23},
        '{FMT_S32, 1'b0, 0,  0},
        '{FMT_U8,  1'b1, 23, 23},
        '{FMT_S24, 1'b1, 67, 0},
        '{FMT_S16, 1'b0, 0,  67}
    };

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // q30 sine, angle folded into the first quadrant
    function automatic longint unsigned sine_q30(input longint unsigned ang);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x = ang;
        if (x > ANG_PI)
            x = ANG_PI;
        if (x > ANG_HALF_PI)
            x = ANG_PI - x;
        x2 = (x * x) >> 30;
        t  = ANG_ONE;
        for (int i = 0; i < 5; i++)
            t = ANG_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
        s = (x * t) >> 30;
        return (s > ANG_ONE) ? ANG_ONE : s;
    endfunction

    function automatic logic [31:0] to_q31(input logic [31:0] raw);
        case (cur_fmt)
            FMT_U8:  return {raw[7:0] ^ 8'h80, 24'h0};
            FMT_S16: return {raw[15:0], 16'h0};
            FMT_S24: return {raw[23:0], 8'h0};
            default: return raw;
        endcase
    endfunction

    // advances the frame model by one beat and returns the result it owes
    function automatic frame_result_t apply_frame_op(input beat_t bt);
        frame_result_t   res;
        int              pos;
        longint          sum;
        longint          mag;
        longint          val;
        logic [31:0]     a_q;
        res = '{1'b0, '0, '0};
        case (bt.func)
            FUNC_PUSH:
            begin
                if (win_fill < FRAME_LEN)
                begin
                    a_q = to_q31(bt.a_raw);
                    pos = (win_start + win_fill) % FRAME_LEN;
                    win_a_mem[pos] = a_q;
                    win_b_mem[pos] = cur_mono ? a_q : to_q31(bt.b_raw);
                    win_fill++;
                    res.accepted = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (int'(bt.idx) < win_fill)
                begin
                    pos = (win_start + int'(bt.idx)) % FRAME_LEN;
                    sum = longint'($signed(win_a_mem[pos])) + longint'($signed(win_b_mem[pos]));
                    mag = ((sum < 0) ? -sum : sum) * longint'(hann_coef[bt.idx]);
                    // negative sums round toward minus infinity
                    if (sum < 0)
                        val = -((mag + longint'(COEF_TOP)) >> COEF_BITS);
                    else
                        val = mag >> COEF_BITS;
                    res.windowed = val[SUM_W-1:0];
                end
            end
            FUNC_SLIDE:
            begin
                win_fill  = (win_fill > SLIDE_STEP) ? win_fill - SLIDE_STEP : 0;
                win_start = (win_start + SLIDE_STEP) % FRAME_LEN;
            end
            default:
                win_fill = 0;
        endcase
        res.fill = win_fill[FILL_W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'hFFFFFFFF;
            3:       return 32'h00000000;
            4:       return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input beat_t bt, input bit typed, input frame_result_t typed_res);
        frame_result_t exp_res;
        while (send_pct != 0 && $urandom_range(0, 99) < send_pct)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid         <= 1'b1;
        items_ch.func          <= bt.func;
        items_ch.chan_a_sample <= bt.a_raw;
        items_ch.chan_b_sample <= bt.b_raw;
        items_ch.read_index    <= bt.idx;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        exp_res = apply_frame_op(bt);
        pending_results.push_back(typed ? typed_res : exp_res);
        beats_sent++;
    endtask

    task automatic send_op(input func_t func, input bit near_fill);
        beat_t         bt;
        frame_result_t unused;
        unused   = '{1'b0, '0, '0};
        bt.func  = func;
        bt.a_raw = pick_sample();
        bt.b_raw = pick_sample();
        if (near_fill && win_fill > 0 && $urandom_range(0, 9) != 0)
            bt.idx = ADDR_W'($urandom_range(0, win_fill - 1));
        else
            bt.idx = ADDR_W'($urandom_range(0, FRAME_LEN - 1));
        send_beat(bt, 1'b0, unused);
    endtask

    task automatic wait_drained();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SAMPLE_FORMAT)
            cur_fmt = fmt_t'(value);
        else
            cur_mono = value[0];
    endtask

    // result side: random stalls, long hold-offs on request, scoreboard
    initial
    begin
        frame_result_t want;
        int            hold_left;
        hold_left = 0;
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results_ch.valid && results_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (results_ch.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d actual %0d",
                               want.accepted, results_ch.accepted);
                        mismatches++;
                    end
                    if (results_ch.fill_level !== want.fill)
                    begin
                        $error("fill_level: expected %0d actual %0d",
                               want.fill, results_ch.fill_level);
                        mismatches++;
                    end
                    if (results_ch.windowed_value !== want.windowed)
                    begin
                        $error("windowed_value: expected %0d actual %0d",
                               want.windowed, results_ch.windowed_value);
                        mismatches++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    initial
    begin
        beat_t         bt;
        frame_result_t typed_res;
        longint unsigned ang;
        longint unsigned s;
        longint unsigned w;
        longint unsigned c;
        int            roll;
        int            len;
        int            target;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_SAMPLE_FORMAT;
        cfg_data               <= '0;
        items_ch.valid         <= 1'b0;
        items_ch.func          <= FUNC_PUSH;
        items_ch.chan_a_sample <= '0;
        items_ch.chan_b_sample <= '0;
        items_ch.read_index    <= '0;
        mismatches   = 0;
        beats_sent   = 0;
        send_pct     = 0;
        recv_pct     = 0;
        hold_request = 0;
        cur_fmt      = FMT_S16;
        cur_mono     = 1'b0;
        win_fill     = 0;
        win_start    = 0;
        for (int n = 0; n < FRAME_LEN; n++)
        begin
            win_a_mem[n] = '0;
            win_b_mem[n] = '0;
            ang = (longint'(n) * ANG_PI + (FRAME_LEN - 1) / 2) / (FRAME_LEN - 1);
            s   = sine_q30(ang);
            w   = (s * s) >> 30;
            c   = (w * COEF_TOP + (ANG_ONE >> 1)) >> 30;
            hann_coef[n] = (c > COEF_TOP) ? COEF_TOP[COEF_BITS-1:0] : c[COEF_BITS-1:0];
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset configuration, no idling
        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                bt.func   = plan[r].func;
                bt.idx    = plan[r].idx;
                bt.a_raw  = (plan[r].reps > 1) ? $urandom : plan[r].a_raw;
                bt.b_raw  = (plan[r].reps > 1) ? $urandom : plan[r].b_raw;
                typed_res = '{plan[r].accepted, plan[r].fill, plan[r].windowed};
                send_beat(bt, plan[r].typed, typed_res);
            end
        end
        wait_drained();

        foreach (phases[p])
        begin
            write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(phases[p].fmt));
            write_reg(CFG_MONO_MODE, CFG_DATA_W'(phases[p].mono));
            send_pct = phases[p].send_pct;
            recv_pct = phases[p].recv_pct;
            target   = beats_sent + PHASE_ITEMS;

            // fill the frame to the brim and knock on it a few times
            if (p == 3)
                repeat (FRAME_LEN - win_fill + 3)
                    send_op(FUNC_PUSH, 1'b0);
            // receiver holds off while beats keep coming, so the input backs up
            if (p == 4)
                hold_request = 300;

            while (beats_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    len = $urandom_range(1, 40);
                    repeat (len)
                        send_op(FUNC_PUSH, 1'b0);
                end
                else if (roll < 75)
                begin
                    len = $urandom_range(1, 30);
                    repeat (len)
                        send_op(FUNC_READ, 1'b1);
                end
                else if (roll < 84)
                    send_op(FUNC_SLIDE, 1'b0);
                else if (roll < 88)
                    send_op(FUNC_CLEAR, 1'b0);
                else
                begin
                    len = $urandom_range(1, 4);
                    repeat (len)
                        send_op(func_t'($urandom_range(0, 3)), 1'b0);
                end
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
